// File: rtl/core/generational_handle_table_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the generational handle table unit
// Simulation-only concurrent checks, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset
`define GHTU_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, sampled on clk_i, off during reset
`define GHTU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define GHTU_ASSERT_IMPL(lbl, pre, post, msg)
`define GHTU_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: rtl/core/ght_pkg.sv
// ---------------------------------------------------------------------------
// Generational handle table package
// Request/response types, opcodes, states and search constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ght_pkg;

  // Opcode values of a request
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;

  // Free-slot search groups the alive bits in rows of this size
  localparam int GRP_W  = 64;
  localparam int GRP_LW = 6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  handle_index;
    logic [31:0] handle_generation;
  } ght_req_t;

  typedef struct packed {
    logic        ok;
    logic [6:0]  result_index;
    logic [31:0] result_generation;
  } ght_rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ght_state_e;

endpackage

// File: rtl/core/generational_handle_table_unit.sv
// ---------------------------------------------------------------------------
// Generational handle table unit
// Fixed table of slots with alive bit and 32-bit generation; allocates the
// lowest free slot, releases and checks generational handles.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | in_req_i  (ght_req_t)
//  out     | output    | out_valid_o / out_stall_i | out_rsp_o (ght_rsp_t)
//
//  Each request is handled in two steps: accept with the generation memory read,
//  then execute with the write-back; the memory read-modify-write sets this.
//  After reset a clearing pass sets every generation to one; requests are
//  stalled meanwhile.
//  A stalled output holds the execute cycle until the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generational_handle_table_unit_macros.svh"

module generational_handle_table_unit
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ght_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ght_rsp_t out_rsp_o
);

  localparam int SW   = $clog2(SLOT_COUNT);
  localparam int NGRP = (SLOT_COUNT + GRP_W - 1) / GRP_W;
  localparam int GIW  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PADW = NGRP * GRP_W;

  ght_state_e state_q, state_d;

  logic [SLOT_COUNT-1:0] alive_q, alive_d;
  logic [NGRP-1:0]       grp_free_q, grp_free_d;
  logic [GRP_LW-1:0]     grp_low_q [NGRP];
  logic [GRP_LW-1:0]     grp_low_d [NGRP];
  logic [PADW-1:0]       alive_pad;

  logic [31:0] gen_mem [SLOT_COUNT];
  logic [31:0] rdata_q;
  logic        mem_we;
  logic [SW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [SW-1:0] rd_addr;

  logic [SW-1:0] clr_q, clr_d;

  ght_req_t      req_q;
  logic [SW-1:0] slot_q, slot_d;
  logic          hit_q, hit_d;

  logic          alloc_found;
  logic [GIW-1:0] alloc_grp;
  logic [31:0]   alloc_pos;
  logic [SW-1:0] alloc_slot;
  logic [31:0]   hpos;
  logic          h_in_range;

  logic          in_acc;
  logic          out_free;
  logic          out_load;
  logic          out_valid_q;
  ght_rsp_t      out_q, rsp_d;
  logic          h_valid;
  logic [31:0]   gen_use;
  logic [31:0]   gen_next;
  logic [31:0]   ridx_w;

  // Handshake
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Pad the next alive vector with busy slots up to whole groups
  always_comb begin
    for (int i = 0; i < PADW; i++) begin
      if (i < SLOT_COUNT) begin
        alive_pad[i] = alive_d[i];
      end else begin
        alive_pad[i] = 1'b1;
      end
    end
  end

  // First search level: lowest free position inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_free_d[g] = ~(&alive_pad[g*GRP_W +: GRP_W]);
      grp_low_d[g]  = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (!alive_pad[g*GRP_W + b]) begin
          grp_low_d[g] = GRP_LW'(b);
        end
      end
    end
  end

  // Hold the group summary in step with the alive bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_free_q <= '1;
      for (int g = 0; g < NGRP; g++) begin
        grp_low_q[g] <= '0;
      end
    end else begin
      grp_free_q <= grp_free_d;
      for (int g = 0; g < NGRP; g++) begin
        grp_low_q[g] <= grp_low_d[g];
      end
    end
  end

  // Second search level: lowest group with a free slot
  always_comb begin
    alloc_found = 1'b0;
    alloc_grp   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        alloc_found = 1'b1;
        alloc_grp   = GIW'(g);
      end
    end
    alloc_pos  = 32'(alloc_grp) * GRP_W + 32'(grp_low_q[alloc_grp]);
    alloc_slot = alloc_pos[SW-1:0];
  end

  // Decode the handle position
  assign hpos       = 32'(in_req_i.handle_index) - 32'd1;
  assign h_in_range = (in_req_i.handle_index != 7'd0) &&
                      (32'(in_req_i.handle_index) <= SLOT_COUNT);

  always_comb begin
    if (in_req_i.opcode == OP_ALLOC) begin
      rd_addr = alloc_slot;
      hit_d   = alloc_found;
    end else begin
      rd_addr = hpos[SW-1:0];
      hit_d   = h_in_range;
    end
    slot_d = rd_addr;
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= in_req_i;
      slot_q <= slot_d;
      hit_q  <= hit_d;
    end
  end

  // Generation memory: one write per cycle and a registered read while idle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      gen_mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == ST_IDLE) begin
      rdata_q <= gen_mem[rd_addr];
    end
  end

  // Execute: validate, build the response and the write-back
  always_comb begin
    h_valid  = hit_q && alive_q[slot_q] && (rdata_q == req_q.handle_generation);
    gen_use  = (rdata_q == 32'd0) ? 32'd1 : rdata_q;
    gen_next = (rdata_q == 32'hFFFF_FFFF) ? 32'd1 : rdata_q + 32'd1;
    ridx_w   = 32'(slot_q) + 32'd1;
    rsp_d    = '0;
    case (req_q.opcode)
      OP_ALLOC: begin
        if (hit_q) begin
          rsp_d.ok                = 1'b1;
          rsp_d.result_index      = ridx_w[6:0];
          rsp_d.result_generation = gen_use;
        end
      end
      OP_RELEASE, OP_CHECK: begin
        if (h_valid) begin
          rsp_d.ok           = 1'b1;
          rsp_d.result_index = req_q.handle_index;
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  // Sequencer: clearing pass, accept, execute
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    alive_d   = alive_q;
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = gen_use;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 32'd1;
        clr_d     = clr_q + SW'(1);
        if (clr_q == SW'(SLOT_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (req_q.opcode == OP_ALLOC && hit_q) begin
            mem_we          = 1'b1;
            mem_wdata       = gen_use;
            alive_d[slot_q] = 1'b1;
          end else if (req_q.opcode == OP_RELEASE && h_valid) begin
            mem_we          = 1'b1;
            mem_wdata       = gen_next;
            alive_d[slot_q] = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      alive_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      alive_q <= alive_d;
    end
  end

  // Output register: load on execute, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= rsp_d;
    end
  end

  // Checks
  `GHTU_ASSERT_NEXT(a_exec_loads_out, state_q == ST_EXEC && out_free, out_valid_o && state_q == ST_IDLE, "execute did not deliver its response")
  `GHTU_ASSERT_IMPL(a_clear_stalls, state_q == ST_CLEAR, in_stall_o, "request accepted during clearing pass")
  `GHTU_ASSERT_IMPL(a_fail_zero, out_valid_o && !out_rsp_o.ok, out_rsp_o.result_index == 7'd0 && out_rsp_o.result_generation == 32'd0, "failed response carries data")
  `GHTU_ASSERT_IMPL(a_alloc_gen_nonzero, out_valid_o && out_rsp_o.ok && out_rsp_o.result_generation != 32'd0, out_rsp_o.result_index != 7'd0 || SLOT_COUNT > 127, "allocation returned index zero")

endmodule
